[sv/rgb_median_filter_3x3_assert.svh]
// assertion macros for the 3x3 median filter
`ifndef RGB_MEDIAN_FILTER_3X3_ASSERT_SVH
`define RGB_MEDIAN_FILTER_3X3_ASSERT_SVH
`define RMF_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rmf check failed");
`define RMF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rmf check failed");
`endif

[sv/rmf_pkg.sv]
// ----------------------------------------------------------------------------
// rmf_pkg
// shared types and constants of the 3x3 median filter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package rmf_pkg;
  localparam int unsigned MaxWidth = 1024;
  localparam int unsigned ColW = $clog2(MaxWidth + 1);
  localparam int unsigned AddrW = $clog2(MaxWidth);
  localparam int unsigned CfgW = 16;
  localparam int unsigned IdxW = 1;
  localparam logic [IdxW-1:0] RegWidth = 1'b0;
  localparam logic [IdxW-1:0] RegHeight = 1'b1;
  localparam logic KindPixel = 1'b0;
  localparam logic KindFlush = 1'b1;

  typedef logic [23:0] pix_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       frame_end;
  } out_item_t;

  typedef struct packed {
    logic [7:0] lo;
    logic [7:0] hi;
  } pair_t;

  function automatic pair_t sort2(input logic [7:0] a, input logic [7:0] b);
    pair_t p;
    p.lo = (a < b) ? a : b;
    p.hi = (a < b) ? b : a;
    return p;
  endfunction
endpackage
`default_nettype wire

[sv/rmf_ram.sv]
// ----------------------------------------------------------------------------
// rmf_ram
// generic simple dual port ram with registered read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module rmf_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

[sv/rmf_med9.sv]
// ----------------------------------------------------------------------------
// rmf_med9
// median of nine 8-bit values, one channel, registered midway
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module rmf_med9 (
  input  wire logic       clk_i,
  input  wire logic       en_i,
  input  wire logic [7:0] v_i [9],
  output logic      [7:0] med_o
);
  import rmf_pkg::*;
  logic [7:0] s [3][3];
  logic [7:0] mx_d, md_d, mn_d;
  logic [7:0] mx_q, md_q, mn_q;
  logic [7:0] a0, a1, a2;
  pair_t p0, p1, p2, pm, q;

  // sort each column of three
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      p0 = sort2(v_i[c*3], v_i[c*3+1]);
      p1 = sort2(p0.hi, v_i[c*3+2]);
      p2 = sort2(p0.lo, p1.lo);
      s[c][0] = p2.lo;
      s[c][1] = p2.hi;
      s[c][2] = p1.hi;
    end
  end

  // max of mins, median of mids, min of maxes
  always_comb begin
    mx_d = (s[0][0] > s[1][0]) ? ((s[0][0] > s[2][0]) ? s[0][0] : s[2][0])
                               : ((s[1][0] > s[2][0]) ? s[1][0] : s[2][0]);
    mn_d = (s[0][2] < s[1][2]) ? ((s[0][2] < s[2][2]) ? s[0][2] : s[2][2])
                               : ((s[1][2] < s[2][2]) ? s[1][2] : s[2][2]);
    pm = sort2(s[0][1], s[1][1]);
    a0 = (pm.hi < s[2][1]) ? pm.hi : s[2][1];
    md_d = (pm.lo > a0) ? pm.lo : a0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mx_q <= mx_d;
      md_q <= md_d;
      mn_q <= mn_d;
    end
  end

  always_comb begin
    q = sort2(mx_q, md_q);
    a1 = (q.hi < mn_q) ? q.hi : mn_q;
    a2 = (q.lo > a1) ? q.lo : a1;
    med_o = a2;
  end
endmodule
`default_nettype wire

[sv/rmf_col_cell.sv]
// ----------------------------------------------------------------------------
// rmf_col_cell
// one window column of three pixels, shifted to the next cell on advance
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module rmf_col_cell (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         adv_i,
  input  wire rmf_pkg::pix_t col_i [3],
  output rmf_pkg::pix_t      col_o [3]
);
  import rmf_pkg::*;
  pix_t col_q [3];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 3; r++) col_q[r] <= '0;
    end else if (adv_i) begin
      for (int r = 0; r < 3; r++) col_q[r] <= col_i[r];
    end
  end
  assign col_o = col_q;
endmodule
`default_nettype wire

[sv/rgb_median_filter_3x3.sv]
// Streaming 3x3 RGB median filter. Takes one transfer (pixel or flush) per
// clock with no bubbles while the output is not stalled; the only registers
// from input transfer to result are the ram read and the median register.
// Each result belongs to the pixel width+1 positions earlier; after the last
// pixel, flush transfers drain the remaining results from the line stores,
// one per transfer. Border pixels pass through, interior ones get the
// per-channel median. Writing either register restarts the frame. The two
// line stores are rams and read through their registered port.
// ----------------------------------------------------------------------------
// rgb_median_filter_3x3
// top level: geometry control, line stores, window cells and median units
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module rgb_median_filter_3x3 (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [rmf_pkg::IdxW-1:0] cfg_idx_i,
  input  wire logic [rmf_pkg::CfgW-1:0] cfg_data_i,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire rmf_pkg::in_item_t        in_data_i,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output rmf_pkg::out_item_t            out_data_o
);
  import rmf_pkg::*;

  logic [10:0] wreg_q;
  logic [15:0] hreg_q;
  logic [ColW-1:0] w;
  logic [15:0] h;
  logic [ColW-1:0] col_q;
  logic [15:0] row_q;
  logic [ColW:0] pend_q;
  logic draining, acc, adv, is_pix, is_fl, s0_adv;

  // stage 0 -> stage 1 (ram read) registers
  logic s1_v_q, s1_fl_q, s1_mode_q, s1_last_q, s1_edge_q, s1_upsel_q, s1_med_q;
  logic s1_adv_q;
  pix_t s1_px_q;
  // stage 2 (median) registers
  logic s2_v_q, s2_fl_q, s2_upsel_q, s2_last_q, s2_med_q;
  pix_t s2_bypass_q, s2_fl_up_q, s2_fl_lo_q;
  logic [ColW-1:0] addr;
  logic [AddrW-1:0] raddr;
  pix_t up_rd, lo_rd;
  pix_t up_eff, lo_eff;
  logic byp_q;
  pix_t byp_up_q, byp_lo_q;
  logic ram_we;
  logic [AddrW-1:0] s1_addr_q;
  pix_t cin [1:3][3];
  logic [7:0] tap [3][9];
  logic [7:0] med [3];
  logic st2_en;

  assign w = (wreg_q == '0) ? ColW'(1) :
             ({1'b0, wreg_q} > (ColW+1)'(MaxWidth)) ? ColW'(MaxWidth) : ColW'(wreg_q);
  assign h = (hreg_q == '0) ? 16'd1 : hreg_q;
  assign draining = (col_q == '0) && (row_q == '0) && (pend_q != '0);

  // output slot frees when empty or taken
  assign st2_en = !s2_v_q || !out_valid_o || !out_stall_i;
  assign in_stall_o = !st2_en;
  assign acc = in_valid_i && !in_stall_o;
  assign is_pix = acc && (in_data_i.kind == KindPixel);
  assign is_fl = acc && (in_data_i.kind == KindFlush) && draining;
  assign adv = st2_en;

  // while stalled, re-read the address of the transfer held in stage 1
  always_comb begin
    if (is_fl) begin
      addr = (pend_q > {1'b0, w}) ? (w - ColW'(1)) : ColW'({1'b0, w} - pend_q);
    end else begin
      addr = col_q;
    end
    raddr = adv ? addr[AddrW-1:0] : s1_addr_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wreg_q <= 11'd640;
      hreg_q <= 16'd480;
      col_q <= '0;
      row_q <= '0;
      pend_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegWidth:  wreg_q <= cfg_data_i[10:0];
        RegHeight: hreg_q <= cfg_data_i;
        default: ;
      endcase
      col_q <= '0;
      row_q <= '0;
      pend_q <= '0;
    end else if (is_fl) begin
      pend_q <= pend_q - (ColW+1)'(1);
    end else if (is_pix) begin
      if (draining) pend_q <= (ColW+1)'(1);
      else if (pend_q < {1'b0, w} + (ColW+1)'(1)) pend_q <= pend_q + (ColW+1)'(1);
      if (col_q + ColW'(1) >= w) begin
        col_q <= '0;
        row_q <= (row_q + 16'd1 >= h) ? 16'd0 : row_q + 16'd1;
      end else begin
        col_q <= col_q + ColW'(1);
      end
    end
  end

  // stage 1: ram read in flight
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s1_adv_q <= 1'b0;
    end else if (adv) begin
      s1_v_q <= is_fl || (is_pix && !draining && (pend_q >= {1'b0, w} + (ColW+1)'(1)));
      s1_adv_q <= is_pix;
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_fl_q <= is_fl;
      s1_last_q <= (pend_q == (ColW+1)'(1));
      s1_upsel_q <= (pend_q > {1'b0, w});
      s1_edge_q <= (col_q == '0);
      s1_med_q <= (row_q >= 16'd2) && (col_q >= ColW'(2));
      s1_px_q <= {in_data_i.red_in, in_data_i.green_in, in_data_i.blue_in};
      s1_addr_q <= raddr;
      s1_mode_q <= is_pix;
    end
  end

  // line store writes happen from stage 1, when read data is back
  assign ram_we = adv && s1_adv_q && s1_mode_q;
  rmf_ram #(.Width(24), .Depth(MaxWidth)) u_up (
    .clk_i(clk_i), .we_i(ram_we), .waddr_i(s1_addr_q), .wdata_i(lo_eff),
    .raddr_i(raddr), .rdata_o(up_rd)
  );
  rmf_ram #(.Width(24), .Depth(MaxWidth)) u_lo (
    .clk_i(clk_i), .we_i(ram_we), .waddr_i(s1_addr_q), .wdata_i(s1_px_q),
    .raddr_i(raddr), .rdata_o(lo_rd)
  );

  // forward data written in the same cycle as it is read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else begin
      byp_q <= ram_we && (s1_addr_q == raddr);
    end
  end
  always_ff @(posedge clk_i) begin
    if (ram_we) begin
      byp_up_q <= lo_eff;
      byp_lo_q <= s1_px_q;
    end
  end
  assign up_eff = byp_q ? byp_up_q : up_rd;
  assign lo_eff = byp_q ? byp_lo_q : lo_rd;
  assign s0_adv = adv && s1_adv_q;

  // window chain: cells 1 and 2 hold the left and centre columns
  assign cin[3][0] = up_eff;
  assign cin[3][1] = lo_eff;
  assign cin[3][2] = s1_px_q;
  for (genvar c = 1; c < 3; c++) begin : g_cell
    rmf_col_cell u_cell (
      .clk_i(clk_i), .rst_ni(rst_ni), .adv_i(s0_adv), .col_i(cin[c+1]), .col_o(cin[c])
    );
  end

  for (genvar ch = 0; ch < 3; ch++) begin : g_ch
    always_comb begin
      for (int c = 0; c < 3; c++) begin
        for (int r = 0; r < 3; r++) begin
          tap[ch][r*3+c] = (c == 0) ? cin[1][r][ch*8 +: 8] :
                           (c == 1) ? cin[2][r][ch*8 +: 8] : cin[3][r][ch*8 +: 8];
        end
      end
    end
    rmf_med9 u_med (.clk_i(clk_i), .en_i(adv), .v_i(tap[ch]), .med_o(med[ch]));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (adv) begin
      s2_v_q <= s1_v_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_fl_q <= s1_fl_q;
      s2_upsel_q <= s1_upsel_q;
      s2_last_q <= s1_fl_q && s1_last_q;
      s2_med_q <= s1_med_q && !s1_edge_q;
      s2_bypass_q <= cin[2][1];
      s2_fl_up_q <= up_eff;
      s2_fl_lo_q <= lo_eff;
    end
  end

  assign out_valid_o = s2_v_q;
  always_comb begin
    pix_t p;
    p = s2_fl_q ? (s2_upsel_q ? s2_fl_up_q : s2_fl_lo_q)
                : (s2_med_q ? {med[2], med[1], med[0]} : s2_bypass_q);
    out_data_o.red_out = p[23:16];
    out_data_o.green_out = p[15:8];
    out_data_o.blue_out = p[7:0];
    out_data_o.frame_end = s2_last_q;
  end
endmodule
`default_nettype wire

[sv/rmf_checker.sv]
// ----------------------------------------------------------------------------
// rmf_checker
// port level checks of the 3x3 median filter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "rgb_median_filter_3x3_assert.svh"
module rmf_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_stall_o,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire rmf_pkg::out_item_t out_data_o
);
  import rmf_pkg::*;
  `RMF_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o))
  `RMF_ASSERT_IMPL(a_stall_only_full, in_stall_o, out_valid_o && out_stall_i)
  `RMF_ASSERT_IMPL(a_no_stall_free, !out_valid_o, !in_stall_o)
endmodule
bind rgb_median_filter_3x3 rmf_checker u_rmf_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_stall_o(in_stall_o),
  .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o)
);
`default_nettype wire

[sim/rgb_median_filter_3x3_tb.sv]
// ----------------------------------------------------------------------------
// rgb_median_filter_3x3_tb
// self-checking bench for the streaming 3x3 rgb median filter: frames of
// random geometry and content are streamed in raster order with flush
// transfers to drain them, under several patterns of source idling and sink
// stalls; a behavioural line-store and window model predicts every result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module rgb_median_filter_3x3_tb;
  import rmf_pkg::*;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [IdxW-1:0]    cfg_idx_i = RegWidth;
  logic [CfgW-1:0]    cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  in_item_t           in_data_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  out_item_t          out_data_o;

  rgb_median_filter_3x3 dut (.*);

  always #5 clk_i = ~clk_i;

  // filter model state
  logic [23:0]  upper_row [MaxWidth];
  logic [23:0]  lower_row [MaxWidth];
  logic [23:0]  win [3][3];
  int unsigned  col_pos, row_pos, owed;
  logic [10:0]  width_reg = 11'd640;
  logic [15:0]  height_reg = 16'd480;

  out_item_t    filtered_q [$];
  int unsigned  idle_pct = 0, stall_pct = 0;
  int unsigned  errors = 0, n_checked = 0, n_sent = 0, n_frames = 0;
  int unsigned  quiet_cycles = 0;

  function automatic int unsigned eff_width();
    if (width_reg == 0) return 1;
    if (width_reg > MaxWidth) return MaxWidth;
    return width_reg;
  endfunction

  function automatic int unsigned eff_height();
    return (height_reg == 0) ? 1 : height_reg;
  endfunction

  function automatic logic [7:0] channel_median(int sh);
    logic [7:0] v [9];
    logic [7:0] t;
    for (int i = 0; i < 9; i++) v[i] = win[i / 3][i % 3][sh +: 8];
    for (int i = 0; i < 8; i++)
      for (int j = 0; j < 8 - i; j++)
        if (v[j] > v[j + 1]) begin
          t = v[j]; v[j] = v[j + 1]; v[j + 1] = t;
        end
    return v[4];
  endfunction

  task automatic filter_model_step(input in_item_t it);
    int unsigned w, h, x, y;
    bit draining;
    logic [23:0] px, res;
    w = eff_width();
    h = eff_height();
    x = col_pos;
    y = row_pos;
    draining = (x == 0 && y == 0 && owed != 0);
    res = '0;
    if (it.kind == KindFlush) begin
      if (draining) begin
        px = (owed > w) ? upper_row[w - 1] : lower_row[w - owed];
        filtered_q.push_back('{px[23:16], px[15:8], px[7:0], 1'(owed == 1)});
        owed--;
      end
    end else begin
      if (draining) owed = 0;
      px = {it.red_in, it.green_in, it.blue_in};
      if (x == 0) res = win[1][2];
      for (int r = 0; r < 3; r++) begin
        win[r][0] = win[r][1];
        win[r][1] = win[r][2];
      end
      win[0][2] = upper_row[x];
      win[1][2] = lower_row[x];
      win[2][2] = px;
      upper_row[x] = win[1][2];
      lower_row[x] = px;
      if (x != 0)
        res = (y >= 2 && x >= 2) ? {channel_median(16), channel_median(8), channel_median(0)}
                                 : win[1][1];
      if (owed >= w + 1)
        filtered_q.push_back('{res[23:16], res[15:8], res[7:0], 1'b0});
      else
        owed++;
      if (x + 1 >= w) begin
        col_pos = 0;
        row_pos = (y + 1 >= h) ? 0 : y + 1;
      end else begin
        col_pos = x + 1;
      end
    end
  endtask

  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      in_data_i <= in_item_t'(25'($urandom));
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    filter_model_step(it);
    n_sent++;
  endtask

  task automatic send_pixel();
    in_item_t it;
    it = in_item_t'(25'($urandom));
    it.kind = KindPixel;
    send_item(it);
  endtask

  task automatic send_flush();
    in_item_t it;
    it = in_item_t'(25'($urandom));
    it.kind = KindFlush;
    send_item(it);
  endtask

  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (filtered_q.size() != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [IdxW-1:0] idx, input logic [CfgW-1:0] val);
    settle();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == RegWidth) width_reg = val[10:0];
    else height_reg = val;
    col_pos = 0;
    row_pos = 0;
    owed = 0;
  endtask

  task automatic set_geometry(input int unsigned w, input int unsigned h);
    write_reg(RegWidth, {5'($urandom), 11'(w)});
    write_reg(RegHeight, 16'(h));
  endtask

  task automatic send_frame();
    repeat (eff_width() * eff_height()) send_pixel();
    n_frames++;
  endtask

  task automatic drain_frame();
    while (owed != 0) send_flush();
  endtask

  task automatic test_directed();
    in_item_t it;
    send_flush();
    set_geometry(4, 3);
    for (int i = 0; i < 12; i++) begin
      it.kind = KindPixel;
      it.red_in = (i % 2) ? 8'hff : 8'h00;
      it.green_in = (i % 3) ? 8'h80 : 8'hff;
      it.blue_in = 8'(i * 23);
      send_item(it);
    end
    drain_frame();
    send_flush();
    set_geometry(0, 0);
    send_pixel();
    send_flush();
    send_flush();
    set_geometry(3, 3);
    send_frame();
    send_flush();
    send_pixel();
  endtask

  task automatic test_wide_frames();
    set_geometry(2047, 65535);
    repeat (1030) send_pixel();
    set_geometry(3, 65535);
    repeat (30) send_pixel();
    write_reg(RegHeight, 16'($urandom));
  endtask

  task automatic test_random_frames(input int unsigned budget);
    int unsigned stop_at, r, k;
    stop_at = n_sent + budget;
    while (n_sent < stop_at) begin
      r = $urandom_range(99);
      if (r < 30) begin
        if ($urandom_range(9) == 0)
          set_geometry($urandom_range(0, 40), $urandom_range(0, 4));
        else
          set_geometry($urandom_range(1, 8), $urandom_range(1, 5));
      end
      if ($urandom_range(9) == 0) begin
        k = $urandom_range(1, eff_width() * eff_height());
        repeat (k) send_pixel();
        set_geometry(width_reg, height_reg);
      end else begin
        send_frame();
        r = $urandom_range(99);
        if (r < 55) begin
          drain_frame();
        end else if (r < 70) begin
          k = $urandom_range(0, owed);
          repeat (k) send_flush();
        end
        if ($urandom_range(9) == 0) send_flush();
        if ($urandom_range(19) == 0) settle();
      end
    end
  endtask

  always @(negedge clk_i) out_stall_i <= ($urandom_range(99) < stall_pct);

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (filtered_q.size() == 0) begin
        $display("%0t: unexpected transfer %h", $time, out_data_o);
        errors++;
      end else begin
        if (out_data_o.red_out !== filtered_q[0].red_out ||
            out_data_o.green_out !== filtered_q[0].green_out ||
            out_data_o.blue_out !== filtered_q[0].blue_out ||
            out_data_o.frame_end !== filtered_q[0].frame_end) begin
          $display("%0t: expected rgb %h %h %h end %b, got %h %h %h end %b", $time,
                   filtered_q[0].red_out, filtered_q[0].green_out,
                   filtered_q[0].blue_out, filtered_q[0].frame_end,
                   out_data_o.red_out, out_data_o.green_out,
                   out_data_o.blue_out, out_data_o.frame_end);
          errors++;
        end
        void'(filtered_q.pop_front());
        n_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 5000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < MaxWidth; i++) begin
      upper_row[i] = '0;
      lower_row[i] = '0;
    end
    for (int i = 0; i < 9; i++) win[i / 3][i % 3] = '0;
    col_pos = 0;
    row_pos = 0;
    owed = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_wide_frames();
    test_random_frames(190);
    idle_pct = 67;
    test_random_frames(190);
    idle_pct = 0;
    stall_pct = 67;
    test_random_frames(190);
    idle_pct = 36;
    stall_pct = 36;
    test_random_frames(190);
    settle();
    repeat (20) @(posedge clk_i);
    if (filtered_q.size() != 0) errors++;
    $display("sent %0d transfers over %0d frames, %0d results checked", n_sent, n_frames,
             n_checked);
    $display("covered widths 1 to 1024, drains, aborted frames and stall patterns");
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
